>>> rtl/idpat_pkg.sv
// idpat_pkg: shared types and constants for the id pair allow table
// no dependencies; compiled first
`timescale 1ns / 1ps

package idpat_pkg;

    // fixed field widths
    localparam int ACTION_W = 2;
    localparam int ID_W     = 16;
    localparam int SLOT_W   = 5;
    localparam int COUNT_W  = 6;
    localparam int WORD_W   = 2 * ID_W;

    // default table depth
    localparam int DEFAULT_TABLE_ENTRIES = 32;

    // request action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_CHECK  = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_GET    = 2'd3
    } action_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    // request word as seen by the controller
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ID_W-1:0]     key_vid;
        logic [ID_W-1:0]     key_pid;
        logic [SLOT_W-1:0]   slot;
    } in_word_t;

    // response word
    typedef struct packed {
        logic              ok;
        logic [ID_W-1:0]   read_vid;
        logic [ID_W-1:0]   read_pid;
        logic [COUNT_W-1:0] entry_count;
    } out_word_t;

    // controller to cell ring
    typedef struct packed {
        logic              shift;
        logic [WORD_W-1:0] tail_word;
    } ring_ctl_t;

endpackage

>>> rtl/idpat_if.sv
// idpat_req_if / idpat_rsp_if: valid/ready channels for requests and responses
// depends on idpat_pkg
`timescale 1ns / 1ps

interface idpat_req_if;
    import idpat_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     key_vid;
    logic [ID_W-1:0]     key_pid;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, action, key_vid, key_pid, slot, input ready);
    modport sink   (input valid, action, key_vid, key_pid, slot, output ready);
endinterface

interface idpat_rsp_if;
    import idpat_pkg::*;

    logic               valid;
    logic               ready;
    logic               ok;
    logic [ID_W-1:0]    read_vid;
    logic [ID_W-1:0]    read_pid;
    logic [COUNT_W-1:0] entry_count;

    modport source (output valid, ok, read_vid, read_pid, entry_count, input ready);
    modport sink   (input valid, ok, read_vid, read_pid, entry_count, output ready);
endinterface

>>> rtl/id_pair_allow_table_unit.sv
// id_pair_allow_table_unit: top level of the vendor/product id allow table
// depends on idpat_pkg, idpat_if, idpat_ring, idpat_ctrl
`timescale 1ns / 1ps
//
//  channel | dir | fields
//  --------+-----+---------------------------------------------
//  req     | in  | action, key_vid, key_pid, slot
//  rsp     | out | ok, read_vid, read_pid, entry_count
//
//  a word is latched, then the entry chain rotates a full turn past the head
//  while each entry is compared and rewritten there, then the result is handed off
//  reset clears every entry and the count at once, no sweep needed
//  req.ready is high only while the sequencer is idle
//  a finished response waits in the output register, the next request is
//  taken as soon as the response has moved there

module id_pair_allow_table_unit #(
    parameter int TABLE_ENTRIES = idpat_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  logic               clk,
    input  logic               rst_n,
    idpat_req_if.sink          req,
    idpat_rsp_if.source        rsp
);
    import idpat_pkg::*;

    in_word_t          req_word;
    out_word_t         result;
    ring_ctl_t         ring_ctl;
    logic [WORD_W-1:0] head_word;
    logic [WORD_W-1:0] next_word;
    logic              idle;
    logic              done_valid;
    logic              done_take;
    logic              start;

    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg, out_word_next;

    // request side
    always_comb
    begin
        req_word.action  = req.action;
        req_word.key_vid = req.key_vid;
        req_word.key_pid = req.key_pid;
        req_word.slot    = req.slot;
    end

    assign req.ready = idle;
    assign start     = req.valid && idle;

    // entry chain
    idpat_ring #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ring_ctl),
        .head_word (head_word),
        .next_word (next_word)
    );

    // walk sequencer
    idpat_ctrl #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req_word   (req_word),
        .head_word  (head_word),
        .next_word  (next_word),
        .done_take  (done_take),
        .ctl        (ring_ctl),
        .idle       (idle),
        .done_valid (done_valid),
        .result     (result)
    );

    // output register load
    always_comb
    begin
        done_take      = done_valid && (!out_valid_reg || rsp.ready);
        out_valid_next = done_take || (out_valid_reg && !rsp.ready);
        out_word_next  = done_take ? result : out_word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    // response side
    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_word_reg.ok;
    assign rsp.read_vid    = out_word_reg.read_vid;
    assign rsp.read_pid    = out_word_reg.read_pid;
    assign rsp.entry_count = out_word_reg.entry_count;

endmodule

>>> rtl/idpat_cell.sv
// idpat_cell: one table entry register in the rotating cell chain
// depends on idpat_pkg
`timescale 1ns / 1ps

module idpat_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift,
    input  logic [idpat_pkg::WORD_W-1:0] d,
    output logic [idpat_pkg::WORD_W-1:0] q
);
    import idpat_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    // take the neighbor word on a shift, else hold
    always_comb
    begin
        word_next = shift ? d : word_reg;
    end

    // entry storage, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign q = word_reg;

endmodule

>>> rtl/idpat_ring.sv
// idpat_ring: chain of entry cells rotating toward the head
// depends on idpat_pkg and idpat_cell
`timescale 1ns / 1ps

module idpat_ring #(
    parameter int ENTRIES = idpat_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  idpat_pkg::ring_ctl_t         ctl,
    output logic [idpat_pkg::WORD_W-1:0] head_word,
    output logic [idpat_pkg::WORD_W-1:0] next_word
);
    import idpat_pkg::*;

    logic [WORD_W-1:0] cell_q [ENTRIES];

    // each cell takes its upper neighbor, the last one takes the tail word
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic [WORD_W-1:0] cell_d;

        if (i == ENTRIES - 1)
        begin : g_tail
            assign cell_d = ctl.tail_word;
        end
        else
        begin : g_mid
            assign cell_d = cell_q[i+1];
        end

        idpat_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (ctl.shift),
            .d     (cell_d),
            .q     (cell_q[i])
        );
    end

    assign head_word = cell_q[0];

    // word behind the head, zero for a single-entry table
    if (ENTRIES > 1)
    begin : g_next
        assign next_word = cell_q[1];
    end
    else
    begin : g_no_next
        assign next_word = '0;
    end

endmodule

>>> rtl/idpat_ctrl.sv
// idpat_ctrl: walk sequencer, compares and rewrites the word at the ring head
// depends on idpat_pkg
`timescale 1ns / 1ps

module idpat_ctrl #(
    parameter int ENTRIES = idpat_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  idpat_pkg::in_word_t          req_word,
    input  logic [idpat_pkg::WORD_W-1:0] head_word,
    input  logic [idpat_pkg::WORD_W-1:0] next_word,
    input  logic                         done_take,
    output idpat_pkg::ring_ctl_t         ctl,
    output logic                         idle,
    output logic                         done_valid,
    output idpat_pkg::out_word_t         result
);
    import idpat_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    step_reg, step_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                found_reg, found_next;
    logic [ACTION_W-1:0] action_reg, action_next;
    logic [WORD_W-1:0]   key_reg, key_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                ok_reg, ok_next;
    logic [WORD_W-1:0]   rd_reg, rd_next;

    logic              last_step;
    logic [CMP_W-1:0]  k_c, cnt_c, slot_c;
    logic              in_range, hit, full, slot_ok, at_slot, at_count;
    logic [WORD_W-1:0] tail_word;

    // walk position and compares
    always_comb
    begin
        last_step = (step_reg == IDX_W'(ENTRIES - 1));
        k_c       = CMP_W'(step_reg);
        cnt_c     = CMP_W'(count_reg);
        slot_c    = CMP_W'(slot_reg);
        in_range  = (k_c < cnt_c);
        hit       = in_range && (head_word == key_reg);
        full      = (count_reg == CNT_W'(ENTRIES));
        slot_ok   = (slot_c < cnt_c);
        at_slot   = (k_c == slot_c);
        at_count  = (k_c == cnt_c);
    end

    // word fed back into the tail cell
    always_comb
    begin
        tail_word = head_word;
        case (action_reg)
            ACT_ADD:
            begin
                // earlier entries are all seen by the time the walk reaches the count
                if (at_count && !full && !found_reg)
                begin
                    tail_word = key_reg;
                end
            end
            ACT_REMOVE:
            begin
                // drop the slot entry: pull the next word forward, zero goes in last
                if (slot_ok && !(k_c < slot_c))
                begin
                    tail_word = last_step ? '0 : next_word;
                end
            end
            default:
            begin
                tail_word = head_word;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (last_step)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (done_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctl.shift     = (state_reg == ST_WALK);
        ctl.tail_word = tail_word;
        idle          = (state_reg == ST_IDLE);
        done_valid    = (state_reg == ST_DONE);
        result.ok          = ok_reg;
        result.read_vid    = rd_reg[WORD_W-1:ID_W];
        result.read_pid    = rd_reg[ID_W-1:0];
        result.entry_count = COUNT_W'(count_reg);
    end

    // datapath next values
    always_comb
    begin
        step_next   = step_reg;
        count_next  = count_reg;
        found_next  = found_reg;
        action_next = action_reg;
        key_next    = key_reg;
        slot_next   = slot_reg;
        ok_next     = ok_reg;
        rd_next     = rd_reg;
        if (state_reg == ST_IDLE && start)
        begin
            // latch the request word
            step_next   = '0;
            found_next  = 1'b0;
            action_next = req_word.action;
            key_next    = {req_word.key_vid, req_word.key_pid};
            slot_next   = req_word.slot;
            ok_next     = 1'b0;
            rd_next     = '0;
        end
        else if (state_reg == ST_WALK)
        begin
            step_next  = step_reg + 1'b1;
            found_next = found_reg | hit;
            if (action_reg == ACT_GET && at_slot && slot_ok)
            begin
                rd_next = head_word;
            end
            if (last_step)
            begin
                step_next = '0;
                case (action_reg)
                    ACT_CHECK:
                    begin
                        ok_next = found_next;
                    end
                    ACT_ADD:
                    begin
                        ok_next = !full;
                        if (!full && !found_next)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        ok_next = slot_ok;
                        if (slot_ok)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    ACT_GET:
                    begin
                        ok_next = slot_ok;
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            count_reg <= count_next;
        end
    end

    // request and result registers
    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        action_reg <= action_next;
        key_reg    <= key_next;
        slot_reg   <= slot_next;
        ok_reg     <= ok_next;
        rd_reg     <= rd_next;
    end

`ifndef SYNTHESIS
    // count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count past table depth");

    // count only moves on the last walk step
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == ST_WALK && last_step) |=> $stable(count_reg))
        else $error("entry count changed outside the walk end");

    // walk ends in the done state with the step counter back at zero
    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && last_step) |=> (state_reg == ST_DONE && step_reg == '0))
        else $error("walk did not end in done");

    // the ring only rotates during a walk
    a_shift_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift |-> (state_reg == ST_WALK))
        else $error("ring shifted outside a walk");
`endif

endmodule

>>> verif/tb_top.sv
// tb_top: self-checking bench for the vendor/product id allow table
// depends on idpat_pkg, idpat_if and id_pair_allow_table_unit
`timescale 1ns / 1ps

module tb_top;
    import idpat_pkg::*;

    localparam int TABLE_DEPTH = DEFAULT_TABLE_ENTRIES;
    localparam int KEY_POOL    = 48;
    localparam int MAX_REPORTS = 10;

    logic clk;
    logic rst_n;

    idpat_req_if req_ch ();
    idpat_rsp_if rsp_ch ();

    id_pair_allow_table_unit #(
        .TABLE_ENTRIES(TABLE_DEPTH)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // shadow copy of the allow table
    logic [WORD_W-1:0] allow_store [TABLE_DEPTH];
    int                store_count;

    // replies still owed by the block, oldest first
    out_word_t         awaited_replies [$];

    logic [WORD_W-1:0] key_pool [KEY_POOL];
    bit                tx_idle_on;
    bit                rx_idle_on;
    int                rx_hold_request;
    int                rx_hold_left;
    int                fail_count;

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // timeout guard
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // apply one request to the shadow table and return the reply it owes
    function automatic out_word_t apply_table_action(in_word_t w);
        logic [WORD_W-1:0] key;
        out_word_t         r;
        bit                found;
        key   = {w.key_vid, w.key_pid};
        r     = '0;
        found = 1'b0;
        for (int i = 0; i < store_count; i++)
        begin
            if (allow_store[i] == key)
                found = 1'b1;
        end
        case (action_t'(w.action))
            ACT_CHECK:
            begin
                r.ok = found;
            end
            ACT_ADD:
            begin
                // a full table refuses even a pair it already holds
                if (store_count < TABLE_DEPTH)
                begin
                    if (!found)
                    begin
                        allow_store[store_count] = key;
                        store_count++;
                    end
                    r.ok = 1'b1;
                end
            end
            ACT_REMOVE:
            begin
                if (w.slot < store_count)
                begin
                    for (int i = w.slot; i + 1 < store_count; i++)
                        allow_store[i] = allow_store[i + 1];
                    store_count--;
                    allow_store[store_count] = '0;
                    r.ok = 1'b1;
                end
            end
            default:
            begin
                if (w.slot < store_count)
                begin
                    r.read_vid = allow_store[w.slot][WORD_W-1:ID_W];
                    r.read_pid = allow_store[w.slot][ID_W-1:0];
                    r.ok       = 1'b1;
                end
            end
        endcase
        r.entry_count = store_count[COUNT_W-1:0];
        return r;
    endfunction

    // offer one request word and wait until it is taken
    // entered and left just after a falling edge
    task automatic send_word(action_t act, logic [ID_W-1:0] vid, logic [ID_W-1:0] pid,
                             logic [SLOT_W-1:0] slot);
        in_word_t w;
        w.action  = act;
        w.key_vid = vid;
        w.key_pid = pid;
        w.slot    = slot;
        if (tx_idle_on && $urandom_range(99) < 9)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_ch.valid   = 1'b1;
        req_ch.action  = w.action;
        req_ch.key_vid = w.key_vid;
        req_ch.key_pid = w.key_pid;
        req_ch.slot    = w.slot;
        do
            @(posedge clk);
        while (!req_ch.ready);
        awaited_replies.push_back(apply_table_action(w));
        @(negedge clk);
    endtask

    // key source: a held entry, a pool entry for repeats, or anything at all
    function automatic logic [WORD_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (store_count > 0 && roll < 30)
            return allow_store[$urandom_range(store_count - 1)];
        if (roll < 75)
            return key_pool[$urandom_range(KEY_POOL - 1)];
        return $urandom;
    endfunction

    // one random request with the given action mix in percent, rest are gets
    task automatic send_random(int w_check, int w_add, int w_remove);
        action_t           act;
        logic [WORD_W-1:0] key;
        logic [SLOT_W-1:0] slot;
        int                roll;
        roll = $urandom_range(99);
        if (roll < w_check)
            act = ACT_CHECK;
        else if (roll < w_check + w_add)
            act = ACT_ADD;
        else if (roll < w_check + w_add + w_remove)
            act = ACT_REMOVE;
        else
            act = ACT_GET;
        key = pick_key();
        // mostly live slots, some right at the count, some anywhere
        if (store_count > 0 && $urandom_range(99) < 70)
            slot = SLOT_W'($urandom_range(store_count - 1));
        else if ($urandom_range(99) < 50)
            slot = store_count[SLOT_W-1:0];
        else
            slot = SLOT_W'($urandom_range(31));
        send_word(act, key[WORD_W-1:ID_W], key[ID_W-1:0], slot);
    endtask

    task automatic wait_for_replies();
        while (awaited_replies.size() != 0)
            @(negedge clk);
    endtask

    // receiver: random stalls, optional long hold-off
    always @(negedge clk)
    begin
        if (rx_hold_request > 0)
        begin
            rx_hold_left    = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left > 0)
        begin
            rsp_ch.ready = 1'b0;
            rx_hold_left--;
        end
        else if (!rx_idle_on)
            rsp_ch.ready = 1'b1;
        else
            rsp_ch.ready = ($urandom_range(99) >= 9);
    end

    task automatic note_failure(string what, out_word_t exp_w, out_word_t got_w);
        if (fail_count < MAX_REPORTS)
            $display("%0t %s: exp ok=%0b vid=%h pid=%h count=%0d, %s",
                     $realtime, what, exp_w.ok, exp_w.read_vid, exp_w.read_pid,
                     exp_w.entry_count,
                     $sformatf("got ok=%0b vid=%h pid=%h count=%0d",
                               got_w.ok, got_w.read_vid, got_w.read_pid,
                               got_w.entry_count));
        fail_count++;
    endtask

    // reply checker
    always @(posedge clk)
    begin
        out_word_t got_w;
        out_word_t exp_w;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got_w.ok          = rsp_ch.ok;
            got_w.read_vid    = rsp_ch.read_vid;
            got_w.read_pid    = rsp_ch.read_pid;
            got_w.entry_count = rsp_ch.entry_count;
            if (awaited_replies.size() == 0)
                note_failure("unexpected reply", '0, got_w);
            else
            begin
                exp_w = awaited_replies.pop_front();
                if (got_w.ok !== exp_w.ok || got_w.read_vid !== exp_w.read_vid ||
                    got_w.read_pid !== exp_w.read_pid ||
                    got_w.entry_count !== exp_w.entry_count)
                    note_failure("reply mismatch", exp_w, got_w);
            end
        end
    end

    // empty table, extreme keys, duplicates, ignored fields, shifts and clears
    task automatic test_directed();
        send_word(ACT_GET,    16'h0000, 16'h0000, 5'd0);
        send_word(ACT_GET,    16'hffff, 16'hffff, 5'd31);
        send_word(ACT_REMOVE, 16'h0000, 16'h0000, 5'd31);
        send_word(ACT_CHECK,  16'h0000, 16'h0000, 5'd0);
        send_word(ACT_ADD,    16'h0000, 16'h0000, 5'd31);
        send_word(ACT_ADD,    16'hffff, 16'hffff, 5'd0);
        send_word(ACT_ADD,    16'hffff, 16'hffff, 5'd7);
        send_word(ACT_CHECK,  16'h0000, 16'h0000, 5'd31);
        send_word(ACT_CHECK,  16'hffff, 16'h0000, 5'd0);
        send_word(ACT_CHECK,  16'h0000, 16'hffff, 5'd0);
        send_word(ACT_GET,    16'hffff, 16'hffff, 5'd1);
        send_word(ACT_GET,    16'h0000, 16'h0000, 5'd0);
        send_word(ACT_GET,    16'h0000, 16'h0000, 5'd2);
        send_word(ACT_ADD,    16'h1234, 16'habcd, 5'd0);
        send_word(ACT_REMOVE, 16'hffff, 16'hffff, 5'd0);
        send_word(ACT_GET,    16'h0000, 16'h0000, 5'd0);
        send_word(ACT_GET,    16'h0000, 16'h0000, 5'd1);
        send_word(ACT_GET,    16'h0000, 16'h0000, 5'd2);
        send_word(ACT_REMOVE, 16'h0000, 16'h0000, 5'd5);
        send_word(ACT_REMOVE, 16'h1234, 16'habcd, 5'd1);
        send_word(ACT_CHECK,  16'h1234, 16'habcd, 5'd0);
        send_word(ACT_REMOVE, 16'h0000, 16'h0000, 5'd0);
        send_word(ACT_CHECK,  16'hffff, 16'hffff, 5'd0);
    endtask

    // add-heavy until the table is full and adds bounce, then drain it
    task automatic test_fill_and_drain();
        repeat (100) send_random(10, 70, 5);
        repeat (100) send_random(10, 10, 65);
    endtask

    task automatic test_random_mix();
        repeat (200) send_random(25, 25, 25);
    endtask

    // receiver holds off while words keep coming, then the sender drains
    task automatic test_stalled_output();
        rx_hold_request = 300;
        repeat (20) send_random(25, 40, 15);
        req_ch.valid = 1'b0;
        wait_for_replies();
    endtask

    // a long stretch with no idling on either side
    task automatic test_steady_stream();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (120) send_random(20, 45, 20);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // main sequence
    initial
    begin
        req_ch.valid    = 1'b0;
        req_ch.action   = ACT_CHECK;
        req_ch.key_vid  = '0;
        req_ch.key_pid  = '0;
        req_ch.slot     = '0;
        rst_n           = 1'b0;
        store_count     = 0;
        fail_count      = 0;
        tx_idle_on      = 1'b1;
        rx_idle_on      = 1'b1;
        rx_hold_request = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            allow_store[i] = '0;
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_fill_and_drain();
        test_random_mix();
        test_stalled_output();
        test_fill_and_drain();
        test_steady_stream();

        // drain and let any stray reply show up
        req_ch.valid = 1'b0;
        wait_for_replies();
        repeat (3 * (TABLE_DEPTH + 2)) @(posedge clk);
        fail_count += awaited_replies.size();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
